// ===== hw/rtl/fwpe_pkg.sv =====
// Package with the item types, codes and constants of the priority-extract queue.
`default_nettype none

package fwpe_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned TagW   = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  // Request kinds carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_MAX  = 2'd2
  } fwpe_mode_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } fwpe_status_e;

  // Controller sequencing states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POPW,
    S_SCAN,
    S_COMPACT,
    S_DONE
  } fwpe_state_e;

  // One stored queue entry.
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } entry_t;

  localparam int unsigned EntryW = TagW + PrioW;

  // One request item.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [TagW-1:0]  in_tag;
    logic [PrioW-1:0] in_priority;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [TagW-1:0]   out_tag;
    logic [PrioW-1:0]  out_priority;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] entry_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fifo_with_max_priority_extract_top.sv =====
// Queue with head pop and highest-priority extraction, built around one entry RAM.
//
// Requests arrive on the in channel (in_valid_i, in_stall_o, in_i); each item
// is a push, a pop of the head, or a removal of the first entry holding the
// largest priority. Every item gives exactly one result item on the out
// channel (out_valid_o, out_stall_i, out_o) with the removed entry, a status
// and the entry count after the request.
// Items are handled one at a time. A push, an empty or full request and the
// unused mode go straight to the result state, a pop after its RAM read.
// A highest-priority removal runs a scan that reads one RAM entry per cycle
// and then a compaction that moves each later entry down one slot through
// the same single read and write port. The next item is accepted in the
// cycle after the result has been handed to the output register.
// If the receiver stalls with a result already waiting, the next result is
// held inside and no further item is accepted until it moves on.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module fifo_with_max_priority_extract_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire fwpe_pkg::in_item_t  in_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      fwpe_pkg::out_item_t out_o
);

  import fwpe_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic [EntryW-1:0] mem_rdata_raw;

  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  logic      out_valid_q;
  out_item_t out_q;

  // Entry store.
  fwpe_ram #(
    .WIDTH(EntryW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata_raw)
  );

  assign mem_rdata = entry_t'(mem_rdata_raw);

  // Request sequencer.
  fwpe_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // Output register: loads when empty or when its item is taken.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fwpe_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module fwpe_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fwpe_ctrl.sv =====
// Sequencer that runs push, pop, maximum scan and compaction over the entry RAM.
`default_nettype none

module fwpe_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Request channel.
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire fwpe_pkg::in_item_t       in_i,
  // Result handoff to the output register.
  output      logic                     res_valid_o,
  input  wire logic                     res_ready_i,
  output      fwpe_pkg::out_item_t      res_o,
  // Entry RAM port.
  output      logic                     mem_we_o,
  output      logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output      fwpe_pkg::entry_t         mem_wdata_o,
  output      logic                     mem_re_o,
  output      logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  wire fwpe_pkg::entry_t         mem_rdata_i
);

  import fwpe_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Next slot of the circular buffer.
  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  fwpe_state_e     state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;
  logic            rv_q, rv_d;
  logic [CW-1:0]   sc_q, sc_d;
  logic [AW-1:0]   rp_q, rp_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [CW-1:0]   rv_log_q, rv_log_d;
  logic [AW-1:0]   rv_phys_q, rv_phys_d;
  entry_t          best_q, best_d;
  logic [AW-1:0]   best_phys_q, best_phys_d;
  logic [CW-1:0]   best_log_q, best_log_d;
  entry_t          res_ent_q, res_ent_d;
  fwpe_status_e    res_stat_q, res_stat_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  // Scan pointers and result payload.
  always_ff @(posedge clk_i) begin
    sc_q        <= sc_d;
    rp_q        <= rp_d;
    wp_q        <= wp_d;
    rv_log_q    <= rv_log_d;
    rv_phys_q   <= rv_phys_d;
    best_q      <= best_d;
    best_phys_q <= best_phys_d;
    best_log_q  <= best_log_d;
    res_ent_q   <= res_ent_d;
    res_stat_q  <= res_stat_d;
  end

  // Next state, RAM requests and result assembly.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    rv_d        = 1'b0;
    sc_d        = sc_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    rv_log_d    = rv_log_q;
    rv_phys_d   = rv_phys_q;
    best_d      = best_q;
    best_phys_d = best_phys_q;
    best_log_d  = best_log_q;
    res_ent_d   = res_ent_q;
    res_stat_d  = res_stat_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wp_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = rp_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          res_ent_d  = '0;
          res_stat_d = STATUS_OK;
          state_d    = S_DONE;
          case (fwpe_mode_e'(in_i.mode))
            MODE_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                res_stat_d = STATUS_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = tail_q;
                mem_wdata_o = '{tag: in_i.in_tag, prio: in_i.in_priority};
                tail_d      = nxt(tail_q);
                count_d     = count_q + CW'(1);
              end
            end
            MODE_POP: begin
              if (count_q == '0) begin
                res_stat_d = STATUS_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                head_d      = nxt(head_q);
                count_d     = count_q - CW'(1);
                state_d     = S_POPW;
              end
            end
            MODE_MAX: begin
              if (count_q == '0) begin
                res_stat_d = STATUS_EMPTY;
              end else begin
                sc_d    = '0;
                rp_d    = head_q;
                state_d = S_SCAN;
              end
            end
            default: begin
              // Unused mode: no change, zero payload.
            end
          endcase
        end
      end

      S_POPW: begin
        res_ent_d = mem_rdata_i;
        state_d   = S_DONE;
      end

      S_SCAN: begin
        // Keep the first entry holding the strictly largest priority.
        if (rv_q && (rv_log_q == '0 || mem_rdata_i.prio > best_q.prio)) begin
          best_d      = mem_rdata_i;
          best_phys_d = rv_phys_q;
          best_log_d  = rv_log_q;
        end
        // One read issued per cycle in queue order.
        if (sc_q != count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rp_q;
          rp_d        = nxt(rp_q);
          sc_d        = sc_q + CW'(1);
          rv_d        = 1'b1;
          rv_log_d    = sc_q;
          rv_phys_d   = rp_q;
        end else if (!rv_q) begin
          wp_d    = best_phys_q;
          rp_d    = nxt(best_phys_q);
          sc_d    = best_log_q + CW'(1);
          state_d = S_COMPACT;
        end
      end

      S_COMPACT: begin
        // Each entry after the removed one moves down by one slot.
        if (rv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wp_q;
          mem_wdata_o = mem_rdata_i;
          wp_d        = nxt(wp_q);
        end
        if (sc_q != count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rp_q;
          rp_d        = nxt(rp_q);
          sc_d        = sc_q + CW'(1);
          rv_d        = 1'b1;
        end else if (!rv_q) begin
          tail_d     = wp_q;
          count_d    = count_q - CW'(1);
          res_ent_d  = best_q;
          res_stat_d = STATUS_OK;
          state_d    = S_DONE;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result item; the count is settled by the time the result is offered.
  assign res_o = '{
    out_tag:      res_ent_q.tag,
    out_priority: res_ent_q.prio,
    status:       res_stat_q,
    entry_count:  CountW'(count_q)
  };

endmodule

`default_nettype wire

// ===== test/fwpe_checker.sv =====
// Checker that predicts each result of the priority-extract queue and compares it.
module fwpe_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  fwpe_pkg::in_item_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  fwpe_pkg::out_item_t out_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o
);
  import fwpe_pkg::*;

  // Predicted queue contents, head at index 0.
  entry_t      shadow_q[$];
  // Results predicted for accepted items, oldest first.
  out_item_t   result_q[$];
  int unsigned fails = 0;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  // Apply one request to the shadow queue and return the result it gives.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t res;
    int        pick;
    res = '0;
    case (req.mode)
      MODE_PUSH: begin
        if (shadow_q.size() >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_q.push_back(entry_t'{tag: req.in_tag, prio: req.in_priority});
        end
      end
      MODE_POP, MODE_MAX: begin
        if (shadow_q.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          pick = 0;
          // The first entry holding the largest priority wins a tie.
          if (req.mode == MODE_MAX) begin
            for (int i = 1; i < shadow_q.size(); i++) begin
              if (shadow_q[i].prio > shadow_q[pick].prio) begin
                pick = i;
              end
            end
          end
          res.out_tag      = shadow_q[pick].tag;
          res.out_priority = shadow_q[pick].prio;
          shadow_q.delete(pick);
        end
      end
      default: begin
        // The unused mode leaves the queue alone.
      end
    endcase
    res.entry_count = CountW'(shadow_q.size());
    return res;
  endfunction

  // Report one field that differs from its prediction.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Predict on every accepted request and compare every accepted result.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(apply_request(in_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_i);
        end else begin
          want = result_q.pop_front();
          check_field("out_tag", 32'(want.out_tag), 32'(out_i.out_tag));
          check_field("out_priority", 32'(want.out_priority), 32'(out_i.out_priority));
          check_field("status", 32'(want.status), 32'(out_i.status));
          check_field("entry_count", 32'(want.entry_count), 32'(out_i.entry_count));
        end
      end
    end
    pending_o  <= result_q.size();
    fail_cnt_o <= fails;
  end

endmodule

// ===== test/tb_fifo_with_max_priority_extract_top.sv =====
// Testbench top that drives requests and results flow control for the priority-extract queue.
module tb_fifo_with_max_priority_extract_top;
  import fwpe_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned RAND_ITEMS     = 1000;
  localparam int unsigned TAIL_ITEMS     = 150;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Mode code that the block treats as a no-op.
  localparam logic [ModeW-1:0] MODE_NOP  = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_i        = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_o;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned sent_cnt     = 0;
  int unsigned quiet_cycles = 0;
  bit          quiet_tail   = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done    = 1'b0;

  always #2 clk_i = ~clk_i;

  fifo_with_max_priority_extract_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  fwpe_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_i       (in_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_i      (out_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  // Offer one item and hold it until accepted, then maybe idle for a burst.
  task automatic offer(input logic [ModeW-1:0] op, input logic [TagW-1:0] tag,
                       input logic [PrioW-1:0] prio);
    in_i       <= in_item_t'{mode: op, in_tag: tag, in_priority: prio};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt++;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Request stream: directed corner cases, then random traffic, then the verdict.
  initial begin
    int unsigned       push_pct;
    int unsigned       prio_top;
    int unsigned       roll;
    logic [ModeW-1:0]  op;
    logic [PrioW-1:0]  prio;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Removals and the unused mode on an empty queue, ignored fields at zero and at all ones.
    offer(MODE_POP, '0, '0);
    offer(MODE_MAX, 32'hFFFF_FFFF, 8'hFF);
    offer(MODE_NOP, 32'hFFFF_FFFF, 8'hFF);
    // Fill the queue with extreme tags and priorities, two entries tied at the top.
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 2 || i == 9) begin
        prio = 8'hFF;
      end else begin
        prio = PrioW'(i * 13);
      end
      offer(MODE_PUSH, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom(), prio);
    end
    // Push into a full queue, then break the tie twice, then no-op and pop.
    offer(MODE_PUSH, 32'hFFFF_FFFF, 8'hFF);
    offer(MODE_MAX, '0, '0);
    offer(MODE_MAX, '0, '0);
    offer(MODE_NOP, '0, '0);
    offer(MODE_POP, '0, '0);

    // Random traffic in segments whose push share swings between draining and filling.
    push_pct = 50;
    prio_top = 255;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        push_pct = $urandom_range(15, 85);
        prio_top = ($urandom_range(0, 2) == 0) ? 3 : 255;
      end
      if (n == 100) hold_request = 1'b1;
      if (n == RAND_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = MODE_NOP;
      end else if (roll < 3 + push_pct) begin
        op = MODE_PUSH;
      end else if ($urandom_range(0, 1) == 0) begin
        op = MODE_POP;
      end else begin
        op = MODE_MAX;
      end
      offer(op, $urandom(), PrioW'($urandom_range(0, prio_top)));
    end
    in_valid_i <= 1'b0;

    // Let every predicted result arrive, then watch for strays.
    @(posedge clk_i);
    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side flow control: random stall bursts and one long hold-off.
  initial begin
    int unsigned span;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        // Long hold-off so the block fills up and stalls its input.
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rst_ni && !quiet_tail && $urandom_range(0, 5) == 0) begin
        span = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
